/* sv/bale_pkg.sv */
// Shared constants, action and status codes, and the controller/datapath
// command and status structs for the bounded list engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bale_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [2:0] ACT_APPEND = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_INSERT = 3'd2;
  localparam logic [2:0] ACT_FIND   = 3'd3;
  localparam logic [2:0] ACT_COUNT  = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BADPOS   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic load;
    logic scan;
    logic prep;
    logic shift;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_op;
    logic shift_op;
    logic remove_op;
    logic scan_done;
    logic shift_done;
    logic hit;
  } stat_t;

endpackage
`default_nettype wire

/* sv/bale_ctrl.sv */
// Sequencer for the bounded list engine: dispatch, scan, shift, finish.
// Depends on bale_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module bale_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  bale_pkg::stat_t    stat,
  output bale_pkg::cmd_t     cmd
);
  import bale_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DISP  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.scan_op) begin
          state_nxt = S_SCAN;
        end else if (stat.shift_op) begin
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          if (stat.remove_op && stat.hit) begin
            cmd.prep  = 1'b1;
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

/* sv/bale_dp.sv */
// Datapath for the bounded list engine: entry memory, count, scan and
// shift pointer, match tracking and result registers. Depends on bale_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bale_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  bale_pkg::cmd_t          cmd,
  output bale_pkg::stat_t         stat,
  input  wire logic [2:0]         in_action,
  input  wire logic signed [31:0] in_value,
  input  wire logic [4:0]         in_position,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [3:0]              out_found_index,
  output logic [4:0]              out_match_count,
  output logic [4:0]              out_entry_count,
  output logic                    out_is_empty,
  output logic                    out_is_full
);
  import bale_pkg::*;

  logic [31:0]       mem [CAPACITY];

  logic [2:0]        act_r;
  logic [31:0]       val_r;
  logic [4:0]        pos_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rptr_r, rptr_nxt, rptr_dec;
  logic              rd_v_r;
  logic [IDX_W-1:0]  rd_tag_r, tag_nxt;
  logic [31:0]       rd_data_r;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  first_r, first_nxt, last_r, last_nxt;
  logic [CNT_W-1:0]  matches_r, matches_nxt;

  logic              is_find, shift_dn, in_range, eq;
  logic              scan_issue, shift_issue, rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [31:0]       wr_data;
  logic [1:0]        status;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  match_cnt;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [3:0]        out_found_index_r;
  logic [4:0]        out_match_count_r;
  logic [4:0]        out_entry_count_r;
  logic              out_is_empty_r, out_is_full_r;

  assign is_find  = (act_r == ACT_FIND);
  assign shift_dn = (act_r == ACT_REMOVE);
  assign in_range = (rptr_r < cnt_r);
  assign rptr_dec = rptr_r - CNT_W'(1);
  assign eq       = rd_v_r && (rd_data_r == val_r);

  assign scan_issue  = cmd.scan && in_range && !(is_find && hit_r);
  assign shift_issue = cmd.shift && (shift_dn ? in_range : (rptr_r > pos_r));
  assign rd_en       = scan_issue || shift_issue;
  assign rd_addr     = (cmd.shift && !shift_dn) ? rptr_dec[IDX_W-1:0] : rptr_r[IDX_W-1:0];

  assign stat.scan_op    = (act_r == ACT_FIND) || (act_r == ACT_COUNT) ||
                           (act_r == ACT_REMOVE);
  assign stat.shift_op   = (act_r == ACT_INSERT) && (cnt_r < CAP_CNT) && (pos_r <= cnt_r);
  assign stat.remove_op  = shift_dn;
  assign stat.hit        = hit_r;
  assign stat.scan_done  = (!rd_v_r && !in_range) || (is_find && hit_r);
  assign stat.shift_done = !rd_v_r && (shift_dn ? !in_range : (rptr_r <= pos_r));

  always_comb begin
    rptr_nxt    = rptr_r;
    tag_nxt     = rd_tag_r;
    hit_nxt     = hit_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    matches_nxt = matches_r;
    if (cmd.load) begin
      rptr_nxt    = (in_action == ACT_INSERT) ? cnt_r : '0;
      hit_nxt     = 1'b0;
      matches_nxt = '0;
    end else if (cmd.prep) begin
      rptr_nxt = CNT_W'(last_r) + CNT_W'(1);
    end else begin
      if (cmd.scan && eq) begin
        hit_nxt     = 1'b1;
        last_nxt    = rd_tag_r;
        matches_nxt = matches_r + CNT_W'(1);
        if (!hit_r) begin
          first_nxt = rd_tag_r;
        end
      end
      if (rd_en) begin
        if (cmd.shift && !shift_dn) begin
          rptr_nxt = rptr_dec;
          tag_nxt  = rptr_r[IDX_W-1:0];
        end else if (cmd.shift) begin
          rptr_nxt = rptr_r + CNT_W'(1);
          tag_nxt  = rptr_dec[IDX_W-1:0];
        end else begin
          rptr_nxt = rptr_r + CNT_W'(1);
          tag_nxt  = rptr_r[IDX_W-1:0];
        end
      end
    end
  end

  always_comb begin
    status    = ST_OK;
    idx       = '0;
    match_cnt = '0;
    cnt_nxt   = cnt_r;
    wr_en     = cmd.shift && rd_v_r;
    wr_addr   = rd_tag_r;
    wr_data   = rd_data_r;
    if (cmd.finish) begin
      case (act_r)
        ACT_APPEND: begin
          if (cnt_r >= CAP_CNT) begin
            status = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = cnt_r[IDX_W-1:0];
            wr_data = val_r;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        ACT_REMOVE: begin
          if (!hit_r) begin
            status = ST_NOTFOUND;
          end else begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
        ACT_INSERT: begin
          if (cnt_r >= CAP_CNT) begin
            status = ST_FULL;
          end else if (pos_r > cnt_r) begin
            status = ST_BADPOS;
          end else begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(pos_r);
            wr_data = val_r;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        ACT_FIND: begin
          if (!hit_r) begin
            status = ST_NOTFOUND;
          end else begin
            idx = first_r;
          end
        end
        ACT_COUNT: begin
          match_cnt = matches_r;
        end
        ACT_CLEAR: begin
          cnt_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      val_r <= in_value;
      pos_r <= in_position;
    end
    rd_tag_r  <= tag_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    matches_r <= matches_nxt;
    if (cmd.finish) begin
      out_status_r      <= status;
      out_found_index_r <= 4'(idx);
      out_match_count_r <= 5'(match_cnt);
      out_entry_count_r <= 5'(cnt_nxt);
      out_is_empty_r    <= (cnt_nxt == '0);
      out_is_full_r     <= (cnt_nxt == CAP_CNT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rptr_r      <= '0;
      rd_v_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rptr_r      <= rptr_nxt;
      rd_v_r      <= rd_en;
      hit_r       <= hit_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_index_r;
  assign out_match_count = out_match_count_r;
  assign out_entry_count = out_entry_count_r;
  assign out_is_empty    = out_is_empty_r;
  assign out_is_full     = out_is_full_r;

endmodule
`default_nettype wire

/* sv/bounded_array_list_engine.sv */
// Top level of the bounded list engine: joins the sequencer and the datapath.
// Depends on bale_pkg, bale_ctrl and bale_dp.
//
//   channel   direction  handshake             payload
//   in_       input      start high, busy low  in_action, in_value, in_position
//   out_      output     out_valid strobe      out_status .. out_is_full
//
// Append, clear, spare codes, and appends or inserts that are refused go from
// dispatch straight to finish. Find, count and remove read the held entries one
// per cycle (one read and one write port); find stops at its first match.
// Insert shifts the entries from its position up before it writes; a remove
// that finds its value shifts the later entries down after its scan.
// busy falls in the cycle the one-cycle out_valid strobe is shown; the receiver
// cannot stall. Reset empties the list; entries are only read after being written.
`timescale 1ns / 1ps
`default_nettype none
module bounded_array_list_engine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_action,
  input  wire logic signed [31:0] in_value,
  input  wire logic [4:0]         in_position,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [3:0]              out_found_index,
  output logic [4:0]              out_match_count,
  output logic [4:0]              out_entry_count,
  output logic                    out_is_empty,
  output logic                    out_is_full
);
  import bale_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bale_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  bale_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_match_count (out_match_count),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == 5'd0)))
    else $error("empty flag disagrees with entry count");

endmodule
`default_nettype wire
